// File: rtl/jsu_pkg.sv
// Shared types, constants and UTF-8 byte helper for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Default depth of the command queue between front and back
  localparam int JsuQueueDepth = 4;

  // Surrogate ranges and the supplementary plane base
  localparam logic [15:0] SurrHighFirst = 16'hD800;
  localparam logic [15:0] SurrHighLast  = 16'hDBFF;
  localparam logic [15:0] SurrLowFirst  = 16'hDC00;
  localparam logic [15:0] SurrLowLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase      = 21'h10000;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] Lead2    = 8'hC0;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;
  localparam logic [5:0] ContMask = 6'h3F;

  // Lowest byte allowed raw in the string body
  localparam logic [7:0] CtrlLimit = 8'h20;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BAD_U    = 3'd1,
    ERR_BAD_ESC  = 3'd2,
    ERR_CTRL     = 3'd3,
    ERR_NO_QUOTE = 3'd4
  } err_e;

  // One command: held high surrogate bytes, then a code point, then a terminal result
  typedef struct packed {
    logic        a_en;    // emit the held high surrogate as 3 bytes first
    logic [9:0]  pend;    // held high surrogate minus 0xD800
    logic [2:0]  b_len;   // UTF-8 length of the code point, 0 for none
    logic [20:0] b_cp;    // code point
    logic        done;    // closing quote seen
    err_e        err;     // error to report, ERR_NONE for none
  } cmd_t;

  // Byte k of the UTF-8 encoding of cp, which is len bytes long
  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [2:0] len, logic [2:0] k);
    logic [7:0] b;
    b = 8'h00;
    case (len)
      3'd1: b = cp[7:0];
      3'd2: begin
        case (k)
          3'd0:    b = Lead2 | {3'b000, cp[10:6]};
          default: b = ContMark | {2'b00, cp[5:0] & ContMask};
        endcase
      end
      3'd3: begin
        case (k)
          3'd0:    b = Lead3 | {4'b0000, cp[15:12]};
          3'd1:    b = ContMark | {2'b00, cp[11:6] & ContMask};
          default: b = ContMark | {2'b00, cp[5:0] & ContMask};
        endcase
      end
      3'd4: begin
        case (k)
          3'd0:    b = Lead4 | {5'b00000, cp[20:18]};
          3'd1:    b = ContMark | {2'b00, cp[17:12] & ContMask};
          3'd2:    b = ContMark | {2'b00, cp[11:6] & ContMask};
          default: b = ContMark | {2'b00, cp[5:0] & ContMask};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/jsu_front.sv
// Front end: accepts input beats, runs the escape parser, and issues commands.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_mark_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  typedef enum logic [5:0] {
    PH_PLAIN   = 6'b000001,
    PH_ESC     = 6'b000010,
    PH_HEX     = 6'b000100,
    PH_HIGH    = 6'b001000,
    PH_HIGH_BS = 6'b010000,
    PH_LOW_HEX = 6'b100000
  } phase_e;

  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharB      = 8'h62;
  localparam logic [7:0] CharF      = 8'h66;
  localparam logic [7:0] CharN      = 8'h6E;
  localparam logic [7:0] CharR      = 8'h72;
  localparam logic [7:0] CharT      = 8'h74;
  localparam logic [7:0] CharU      = 8'h75;

  // Hex digit value; bit 4 flags a non-hex byte
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  // UTF-8 length of a code point
  function automatic logic [2:0] cp_len(logic [20:0] cp);
    logic [2:0] n;
    if (cp <= 21'h7F) n = 3'd1;
    else if (cp <= 21'h7FF) n = 3'd2;
    else if (cp <= 21'hFFFF) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  phase_e      ph_q, ph_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  pend_q, pend_d;
  logic        fin_q, fin_d;

  logic [4:0]  dig;
  logic [15:0] acc_sh;
  logic        esc_ok;
  logic [7:0]  esc_byte;
  cmd_t        cmd;

  assign dig    = hex_val(in_byte_i);
  assign acc_sh = {acc_q[11:0], dig[3:0]};

  // Decode the simple escapes
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte_i;
    case (in_byte_i)
      CharQuote:  esc_byte = CharQuote;
      CharBslash: esc_byte = CharBslash;
      CharSlash:  esc_byte = CharSlash;
      CharB:      esc_byte = 8'h08;
      CharF:      esc_byte = 8'h0C;
      CharN:      esc_byte = 8'h0A;
      CharR:      esc_byte = 8'h0D;
      CharT:      esc_byte = 8'h09;
      default:    esc_ok   = 1'b0;
    endcase
  end

  // Parse one beat
  always_comb begin
    ph_d   = ph_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    pend_d = pend_q;
    fin_d  = fin_q;
    cmd       = '0;
    cmd.pend  = pend_q;
    cmd.err   = ERR_NONE;

    if (accept_i && !fin_q) begin
      if (end_mark_i) begin
        fin_d = 1'b1;
        ph_d  = PH_PLAIN;
        case (ph_q)
          PH_HIGH, PH_HIGH_BS: begin
            cmd.a_en = 1'b1;
            cmd.err  = ERR_NO_QUOTE;
          end
          PH_LOW_HEX: begin
            cmd.a_en = 1'b1;
            cmd.err  = ERR_BAD_U;
          end
          PH_HEX:  cmd.err = ERR_BAD_U;
          default: cmd.err = ERR_NO_QUOTE;
        endcase
      end else begin
        case (ph_q)
          PH_ESC, PH_HIGH_BS: begin
            if (ph_q == PH_HIGH_BS && in_byte_i != CharU) cmd.a_en = 1'b1;
            ph_d = PH_PLAIN;
            if (in_byte_i == CharU) begin
              ph_d  = (ph_q == PH_HIGH_BS) ? PH_LOW_HEX : PH_HEX;
              acc_d = '0;
              cnt_d = '0;
            end else if (esc_ok) begin
              cmd.b_len = 3'd1;
              cmd.b_cp  = {13'b0, esc_byte};
            end else begin
              cmd.err = ERR_BAD_ESC;
              fin_d   = 1'b1;
            end
          end
          PH_HEX, PH_LOW_HEX: begin
            if (dig[4]) begin
              cmd.a_en = (ph_q == PH_LOW_HEX);
              cmd.err  = ERR_BAD_U;
              fin_d    = 1'b1;
              ph_d     = PH_PLAIN;
            end else begin
              acc_d = acc_sh;
              cnt_d = cnt_q + 2'd1;
              if (cnt_q == 2'd3) begin
                if (ph_q == PH_LOW_HEX && acc_sh >= SurrLowFirst && acc_sh <= SurrLowLast) begin
                  // Combine the surrogate pair into one supplementary code point
                  cmd.b_len = 3'd4;
                  cmd.b_cp  = SuppBase + {1'b0, pend_q, acc_sh[9:0]};
                  ph_d      = PH_PLAIN;
                end else begin
                  // A held high not followed by a low goes out alone
                  cmd.a_en = (ph_q == PH_LOW_HEX);
                  if (acc_sh >= SurrHighFirst && acc_sh <= SurrHighLast) begin
                    pend_d = acc_sh[9:0];
                    ph_d   = PH_HIGH;
                  end else begin
                    cmd.b_len = cp_len({5'b0, acc_sh});
                    cmd.b_cp  = {5'b0, acc_sh};
                    ph_d      = PH_PLAIN;
                  end
                end
              end
            end
          end
          default: begin
            // Plain text, or the byte after a held high; a backslash there may begin the low half
            if (ph_q == PH_HIGH && in_byte_i == CharBslash) begin
              ph_d = PH_HIGH_BS;
            end else begin
              cmd.a_en = (ph_q == PH_HIGH);
              ph_d     = PH_PLAIN;
              if (in_byte_i == CharQuote) begin
                cmd.done = 1'b1;
                fin_d    = 1'b1;
              end else if (in_byte_i == CharBslash) begin
                ph_d = PH_ESC;
              end else if (in_byte_i < CtrlLimit) begin
                cmd.err = ERR_CTRL;
                fin_d   = 1'b1;
              end else begin
                cmd.b_len = 3'd1;
                cmd.b_cp  = {13'b0, in_byte_i};
              end
            end
          end
        endcase
      end
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept_i && !fin_q &&
                  (cmd.a_en || cmd.b_len != 3'd0 || cmd.done || cmd.err != ERR_NONE);

  // Update parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_PLAIN;
      acc_q  <= '0;
      cnt_q  <= '0;
      pend_q <= '0;
      fin_q  <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      fin_q  <= fin_d;
    end
  end

  // Once finished, the parser issues nothing more
  a_fin_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !push_o)
    else $error("command issued after the string finished");

endmodule

`default_nettype wire

// File: rtl/jsu_cmd_fifo.sv
// Command queue between the parser front end and the byte expander.
`timescale 1ns / 1ps
`default_nettype none

module jsu_cmd_fifo
  import jsu_pkg::*;
#(
  parameter int Depth = JsuQueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] nxt(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_cmd_i;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i) rd_q <= nxt(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(push_i && !pop_i))
    else $error("command queue overflow");

endmodule

`default_nettype wire

// File: rtl/jsu_back.sv
// Back end: expands commands into result beats through an output register.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       head_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            string_done_o,
  output logic [2:0]      error_code_o,
  output logic            last_o
);

  cmd_t       cur_q;
  logic       cur_valid_q;
  logic [2:0] idx_q;

  logic       out_valid_q, byte_valid_q, done_q, last_q;
  logic [7:0] byte_q;
  err_e       err_q;

  logic [3:0] n_a, n_ab, total, idx4;
  logic       is_last, adv;
  logic [7:0] r_byte;
  logic       r_bv, r_done;
  err_e       r_err;

  // Size of the current command
  assign idx4    = {1'b0, idx_q};
  assign n_a     = cur_q.a_en ? 4'd3 : 4'd0;
  assign n_ab    = n_a + {1'b0, cur_q.b_len};
  assign total   = n_ab + {3'b000, (cur_q.done || cur_q.err != ERR_NONE)};
  assign is_last = (idx4 + 4'd1 == total);
  assign adv     = cur_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o   = !empty_i && (!cur_valid_q || (adv && is_last));

  // Pick the result at the current index
  always_comb begin
    r_byte = 8'h00;
    r_bv   = 1'b0;
    r_done = 1'b0;
    r_err  = ERR_NONE;
    if (idx4 < n_a) begin
      r_bv   = 1'b1;
      r_byte = utf8_byte({5'b0, SurrHighFirst[15:10], cur_q.pend}, 3'd3, idx_q);
    end else if (idx4 < n_ab) begin
      r_bv   = 1'b1;
      r_byte = utf8_byte(cur_q.b_cp, cur_q.b_len, 3'(idx4 - n_a));
    end else begin
      r_done = cur_q.done;
      r_err  = cur_q.err;
    end
  end

  // Load and step the current command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (adv && is_last) begin
      cur_valid_q <= 1'b0;
    end else if (adv) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q       <= r_byte;
      byte_valid_q <= r_bv;
      done_q       <= r_done;
      err_q        <= r_err;
      last_q       <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = byte_valid_q;
  assign string_done_o = done_q;
  assign error_code_o  = err_q;
  assign last_o        = last_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (idx4 < total))
    else $error("result index past end of command");

  a_term_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (done_q || err_q != ERR_NONE)) |-> last_q)
    else $error("done or error beat not marked last");

  a_kind_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && byte_valid_q) |-> (!done_q && err_q == ERR_NONE))
    else $error("byte beat also carries done or error");

endmodule

`default_nettype wire

// File: rtl/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescaper: front parser, command queue, byte expander.
// Throughput: one input beat per cycle while not stalled. Output runs at one result
// per cycle while out_stall_i is low and commands are available, set by the single
// output register of the back end, which emits the results of a command in turn.
// Input stalls only while the command queue (QueueDepth entries) is full.
// Reset (rst_ni low, asynchronous) returns to plain text with nothing held or queued.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_unit
  import jsu_pkg::*;
#(
  parameter int QueueDepth = JsuQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_mark_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            string_done_o,
  output logic [2:0]      error_code_o,
  output logic            last_o
);

  logic accept, push, pop, empty, full;
  cmd_t push_cmd, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .end_mark_i (end_mark_i),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  jsu_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .string_done_o (string_done_o),
    .error_code_o  (error_code_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
